[src/dd_pkg.sv]
// Shared constants, widths and calendar helpers for the date difference block.
// Depends on nothing; used by dd_leap_unit and date_difference_in_days.
`default_nettype none

package dd_pkg;

    localparam int DAY_W   = 5;
    localparam int MONTH_W = 4;
    localparam int YEAR_W  = 14;
    localparam int COUNT_W = 23;

    localparam logic [YEAR_W-1:0]  MAX_YEAR  = YEAR_W'(9999);
    localparam logic [MONTH_W-1:0] JANUARY   = MONTH_W'(1);
    localparam logic [MONTH_W-1:0] FEBRUARY  = MONTH_W'(2);
    localparam logic [MONTH_W-1:0] DECEMBER  = MONTH_W'(12);
    localparam logic [DAY_W-1:0]   FIRST_DAY = DAY_W'(1);

    // Floor of year / 25 is (year * DIV25_MUL) >> DIV25_SHIFT for any 14-bit year.
    localparam int DIV25_MUL   = 5243;
    localparam int DIV25_SHIFT = 17;

    typedef logic [DAY_W-1:0] t_mlen_table [12];

    localparam t_mlen_table MONTH_LEN = '{
        DAY_W'(31), DAY_W'(28), DAY_W'(31), DAY_W'(30), DAY_W'(31), DAY_W'(30),
        DAY_W'(31), DAY_W'(31), DAY_W'(30), DAY_W'(31), DAY_W'(30), DAY_W'(31)
    };

    // Days in a month; zero for a month code outside January..December.
    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                   input logic leap);
        logic [DAY_W-1:0] len;
        len = '0;
        if (m == FEBRUARY) begin
            len = leap ? DAY_W'(29) : DAY_W'(28);
        end else if (m inside {[JANUARY:DECEMBER]}) begin
            len = MONTH_LEN[m - JANUARY];
        end
        return len;
    endfunction

endpackage

`default_nettype wire

[src/dd_leap_unit.sv]
// Leap-year test for one 14-bit Gregorian year, shared by validation and the walk.
// Depends on dd_pkg for widths and the divide-by-25 reciprocal.
`default_nettype none

module dd_leap_unit
    import dd_pkg::*;
(
    input  wire logic [YEAR_W-1:0] i_year,
    output logic                   o_leap
);

    localparam int PROD_W = 2 * YEAR_W;

    logic [PROD_W-1:0] prod;
    logic [YEAR_W-1:0] quot;
    logic [YEAR_W-1:0] rem25;
    logic              div25;

    // Divisible by 100 means by 4 and 25; by 400 means by 16 and 25.
    assign prod   = PROD_W'(i_year) * PROD_W'(DIV25_MUL);
    assign quot   = YEAR_W'(prod >> DIV25_SHIFT);
    assign rem25  = i_year - YEAR_W'(quot * YEAR_W'(25));
    assign div25  = (rem25 == '0);
    assign o_leap = (i_year[1:0] == 2'b00) && (!div25 || (i_year[3:0] == 4'b0000));

endmodule

`default_nettype wire

[src/date_difference_in_days.sv]
// Sequence: date checks in S_CHKA and S_CHKB, then one S_WALK step per day between the dates
// plus an S_LEAP step per year boundary crossed, a final compare in S_WALK, then the strobe.
// An invalid date strobes right after the checks. A new beat is taken in the strobe cycle.
// Results appear for one cycle with o_valid; the receiver cannot stall.
// Reset (i_rst_n low, synchronous) returns the sequencer to idle and drops o_valid.
// Depends on dd_pkg and dd_leap_unit.
`default_nettype none

module date_difference_in_days
    import dd_pkg::*;
(
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      start,
    output logic                           busy,
    input  wire logic [DAY_W-1:0]          i_start_day,
    input  wire logic [MONTH_W-1:0]        i_start_month,
    input  wire logic [YEAR_W-1:0]         i_start_year,
    input  wire logic [DAY_W-1:0]          i_end_day,
    input  wire logic [MONTH_W-1:0]        i_end_month,
    input  wire logic [YEAR_W-1:0]         i_end_year,
    input  wire logic                      i_include_end_day,
    output logic                           o_valid,
    output logic signed [COUNT_W-1:0]      o_day_count,
    output logic                           o_date_error
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_CHKA = 3'd1;
    localparam logic [2:0] S_CHKB = 3'd2;
    localparam logic [2:0] S_WALK = 3'd3;
    localparam logic [2:0] S_LEAP = 3'd4;

    localparam int DATE_W = YEAR_W + MONTH_W + DAY_W;

    logic [2:0]         r_state, n_state;
    logic [DAY_W-1:0]   r_ad, n_ad, r_bd, n_bd;
    logic [MONTH_W-1:0] r_am, n_am, r_bm, n_bm;
    logic [YEAR_W-1:0]  r_ay, n_ay, r_by, n_by;
    logic               r_inc, n_inc;
    logic               r_leap, n_leap;
    logic               r_neg, n_neg;
    logic               r_err, n_err;
    logic [COUNT_W-1:0] r_cnt, n_cnt;
    logic               r_valid, n_valid;
    logic [COUNT_W-1:0] r_out, n_out;
    logic               r_oerr, n_oerr;

    logic [YEAR_W-1:0]  leap_year;
    logic               leap;
    logic [DAY_W-1:0]   chk_d;
    logic [MONTH_W-1:0] chk_m;
    logic [YEAR_W-1:0]  chk_y;
    logic [DAY_W-1:0]   chk_len;
    logic               chk_ok;
    logic [DAY_W-1:0]   walk_len;
    logic [DATE_W-1:0]  date_a, date_b;
    logic [COUNT_W-1:0] mag;

    // One leap unit serves both checks and each year boundary of the walk.
    always_comb begin
        case (r_state)
            S_CHKB:  leap_year = r_by;
            default: leap_year = r_ay;
        endcase
    end

    dd_leap_unit u_leap (
        .i_year (leap_year),
        .o_leap (leap)
    );

    assign chk_d   = (r_state == S_CHKB) ? r_bd : r_ad;
    assign chk_m   = (r_state == S_CHKB) ? r_bm : r_am;
    assign chk_y   = (r_state == S_CHKB) ? r_by : r_ay;
    assign chk_len = month_len(chk_m, leap);
    assign chk_ok  = (chk_y <= MAX_YEAR) && (chk_len != '0) && (chk_d != '0)
                     && (chk_d <= chk_len);

    assign walk_len = month_len(r_am, r_leap);
    assign date_a   = {r_ay, r_am, r_ad};
    assign date_b   = {r_by, r_bm, r_bd};
    assign mag      = r_cnt + COUNT_W'(r_inc);

    always_comb begin
        n_state = r_state;
        n_ad    = r_ad;
        n_am    = r_am;
        n_ay    = r_ay;
        n_bd    = r_bd;
        n_bm    = r_bm;
        n_by    = r_by;
        n_inc   = r_inc;
        n_leap  = r_leap;
        n_neg   = r_neg;
        n_err   = r_err;
        n_cnt   = r_cnt;
        n_valid = 1'b0;
        n_out   = r_out;
        n_oerr  = r_oerr;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_ad    = i_start_day;
                    n_am    = i_start_month;
                    n_ay    = i_start_year;
                    n_bd    = i_end_day;
                    n_bm    = i_end_month;
                    n_by    = i_end_year;
                    n_inc   = i_include_end_day;
                    n_cnt   = '0;
                    n_state = S_CHKA;
                end
            end
            S_CHKA: begin
                n_err   = !chk_ok;
                n_leap  = leap;
                n_state = S_CHKB;
            end
            S_CHKB: begin
                if (r_err || !chk_ok) begin
                    n_valid = 1'b1;
                    n_out   = '0;
                    n_oerr  = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    // Walk from the earlier date; swap when the end comes first.
                    n_neg = (date_b < date_a);
                    if (date_b < date_a) begin
                        n_ad   = r_bd;
                        n_am   = r_bm;
                        n_ay   = r_by;
                        n_bd   = r_ad;
                        n_bm   = r_am;
                        n_by   = r_ay;
                        n_leap = leap;
                    end
                    n_state = S_WALK;
                end
            end
            S_WALK: begin
                if (date_a == date_b) begin
                    n_valid = 1'b1;
                    n_out   = r_neg ? (COUNT_W'(0) - mag) : mag;
                    n_oerr  = 1'b0;
                    n_state = S_IDLE;
                end else begin
                    n_cnt = r_cnt + COUNT_W'(1);
                    if (r_ad < walk_len) begin
                        n_ad = r_ad + DAY_W'(1);
                    end else begin
                        n_ad = FIRST_DAY;
                        if (r_am < DECEMBER) begin
                            n_am = r_am + MONTH_W'(1);
                        end else begin
                            // New year: refresh the leap flag before the next step.
                            n_am    = JANUARY;
                            n_ay    = r_ay + YEAR_W'(1);
                            n_state = S_LEAP;
                        end
                    end
                end
            end
            S_LEAP: begin
                n_leap  = leap;
                n_state = S_WALK;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ad   <= n_ad;
        r_am   <= n_am;
        r_ay   <= n_ay;
        r_bd   <= n_bd;
        r_bm   <= n_bm;
        r_by   <= n_by;
        r_inc  <= n_inc;
        r_leap <= n_leap;
        r_neg  <= n_neg;
        r_err  <= n_err;
        r_cnt  <= n_cnt;
        r_out  <= n_out;
        r_oerr <= n_oerr;
    end

    assign busy         = (r_state != S_IDLE);
    assign o_valid      = r_valid;
    assign o_day_count  = $signed(r_out);
    assign o_date_error = r_oerr;

`ifndef SYNTHESIS
    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted beat did not start the sequencer");

    a_result_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ($past(busy) && !busy))
        else $error("result beat without a finished item");

    a_error_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_date_error) |-> (o_day_count == '0))
        else $error("invalid date produced a nonzero count");

    a_no_overshoot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK || r_state == S_LEAP) |-> (date_a <= date_b))
        else $error("walking date passed the target date");
`endif

endmodule

`default_nettype wire
